// ----- rtl/core/bmlb_pkg.sv -----
package bmlb_pkg;

	localparam int CNT_W = 16;
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(500);
	localparam logic [CFG_W-1:0] HOLD_RST     = CFG_W'(10000);
	localparam logic [CFG_W-1:0] SLOW_RST     = CFG_W'(50000);
	localparam logic [CFG_W-1:0] FAST_RST     = CFG_W'(5000);

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_HOLD     = 2'd1,
		REG_SLOW     = 2'd2,
		REG_FAST     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_SLOW = 2'd2,
		MODE_FAST = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_limit;
		logic [CFG_W-1:0] hold_limit;
		logic [CFG_W-1:0] slow_period;
		logic [CFG_W-1:0] fast_period;
	} cfg_t;

	typedef struct packed {
		logic             last_button;
		mode_t            mode;
		logic [CNT_W-1:0] blink_count;
		logic             press_pending;
		logic             settling;
		logic [CNT_W-1:0] settle_count;
		logic [CNT_W-1:0] hold_count;
		logic             led;
	} state_t;

	localparam state_t STATE_RST = '{
		last_button:   1'b0,
		mode:          MODE_OFF,
		blink_count:   '0,
		press_pending: 1'b0,
		settling:      1'b0,
		settle_count:  '0,
		hold_count:    '0,
		led:           1'b0
	};

endpackage

// ----- rtl/core/bmlb_cfg.sv -----
module bmlb_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bmlb_pkg::IDX_W-1:0] cfg_index,
	input  logic [bmlb_pkg::CFG_W-1:0] cfg_data,
	output bmlb_pkg::cfg_t            cfg
);
	import bmlb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_limit <= DEBOUNCE_RST;
			cfg_q.hold_limit     <= HOLD_RST;
			cfg_q.slow_period    <= SLOW_RST;
			cfg_q.fast_period    <= FAST_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_limit <= cfg_data;
				REG_HOLD:     cfg_q.hold_limit     <= cfg_data;
				REG_SLOW:     cfg_q.slow_period    <= cfg_data;
				REG_FAST:     cfg_q.fast_period    <= cfg_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/bmlb_tick.sv -----
module bmlb_tick (
	input  bmlb_pkg::cfg_t   cfg,
	input  bmlb_pkg::state_t cur,
	input  logic             button,
	output bmlb_pkg::state_t nxt
);
	import bmlb_pkg::*;

	logic [CFG_W-1:0] period;
	logic [CNT_W-1:0] blink_inc;
	logic [CNT_W-1:0] blink_wrap;
	logic             blink_led;

	always_comb begin
		nxt = cur;

		// rising edge
		if (button && !cur.last_button) begin
			nxt.blink_count   = '0;
			nxt.press_pending = 1'b1;
		end
		nxt.last_button = button;

		// hold forces off
		if (button) begin
			nxt.hold_count = cur.hold_count + CNT_W'(1);
			if (32'(nxt.hold_count) > 32'(cfg.hold_limit)) begin
				nxt.mode       = MODE_OFF;
				nxt.hold_count = '0;
			end
		end else begin
			nxt.hold_count = '0;
		end

		// debounce
		if (nxt.press_pending && !cur.settling) begin
			nxt.settling      = 1'b1;
			nxt.settle_count  = '0;
			nxt.press_pending = 1'b0;
		end
		if (nxt.settling) begin
			nxt.settle_count = nxt.settle_count + CNT_W'(1);
			if (32'(nxt.settle_count) >= 32'(cfg.debounce_limit)) begin
				nxt.settling     = 1'b0;
				nxt.settle_count = '0;
				if (button)
					nxt.mode = mode_t'(nxt.mode + 2'd1);
			end
		end

		// blink count step, used only in the blink modes
		period     = (nxt.mode == MODE_SLOW) ? cfg.slow_period : cfg.fast_period;
		blink_inc  = nxt.blink_count + CNT_W'(1);
		blink_wrap = blink_inc;
		if (32'(blink_inc) >= 32'(period))
			blink_wrap = CNT_W'(32'(blink_inc) - 32'(period));
		blink_led  = 32'(blink_wrap) >= 32'(period >> 1);

		// final mode drives the LED and blink count
		case (nxt.mode)
			MODE_OFF: nxt.led = 1'b0;
			MODE_ON:  nxt.led = 1'b1;
			default: begin
				nxt.led         = blink_led;
				nxt.blink_count = blink_wrap;
			end
		endcase
	end

endmodule

// ----- rtl/core/button_mode_led_blinker.sv -----
// An accepted request is held in the input stage, then its result in the result
// register. Throughput: one request per cycle; req_stall rises only while the
// result register is full and stalled and a request already waits in stage one.
// Reset (arst_n low, asynchronous): state cleared to mode off and LED low,
// handshake cleared, configuration back to defaults; led/mode outputs not reset.
module button_mode_led_blinker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      button,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      led,
	output logic [1:0]                mode,
	input  logic                      cfg_we,
	input  logic [bmlb_pkg::IDX_W-1:0] cfg_index,
	input  logic [bmlb_pkg::CFG_W-1:0] cfg_data
);
	import bmlb_pkg::*;

	cfg_t   cfg;
	state_t state_q;
	state_t state_nxt;

	logic   valid_s1;
	logic   button_s1;
	logic   valid_s2;
	logic   led_s2;
	mode_t  mode_s2;
	logic   advance;

	bmlb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bmlb_tick u_tick (
		.cfg    (cfg),
		.cur    (state_q),
		.button (button_s1),
		.nxt    (state_nxt)
	);

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RST;
		end else begin
			if (!req_stall)
				valid_s1 <= req_valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			button_s1 <= button;
		if (advance) begin
			led_s2  <= state_nxt.led;
			mode_s2 <= state_nxt.mode;
		end
	end

	assign rsp_valid = valid_s2;
	assign led       = led_s2;
	assign mode      = mode_s2;

endmodule

// ----- rtl/core/bmlb_chk.sv -----
module bmlb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic       led,
	input logic [1:0] mode
);
	import bmlb_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(led) && $stable(mode))
		else $error("stalled result changed");

	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled while result side free");

	a_off_led: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && mode == MODE_OFF |-> !led)
		else $error("LED lit in off mode");

	a_on_led: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && mode == MODE_ON |-> led)
		else $error("LED dark in on mode");

endmodule

bind button_mode_led_blinker bmlb_chk u_bmlb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.led       (led),
	.mode      (mode)
);

// ----- tb/blinker_checker.sv -----
module blinker_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic                       button,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  logic                       led,
	input  logic [1:0]                 mode,
	input  logic                       cfg_we,
	input  logic [bmlb_pkg::IDX_W-1:0] cfg_index,
	input  logic [bmlb_pkg::CFG_W-1:0] cfg_data,
	output int                         errors,
	output int                         outstanding,
	output int                         compared
);
	import bmlb_pkg::*;

	typedef struct packed {
		logic  led;
		mode_t mode;
	} lamp_t;

	cfg_t   cfg;
	state_t st;
	lamp_t  lamp_q[$];

	// count up, fold back once by the period, LED high in the second half
	function automatic logic blink_step(input logic [CNT_W-1:0] period);
		logic [CNT_W-1:0] c;
		c = st.blink_count + 1'b1;
		if (c >= period)
			c = c - period;
		st.blink_count = c;
		return c >= (period >> 1);
	endfunction

	function automatic lamp_t advance_tick(input logic b);
		logic [1:0] next_mode;
		lamp_t      r;
		if (b && !st.last_button) begin
			st.blink_count   = '0;
			st.press_pending = 1'b1;
		end
		st.last_button = b;

		if (b) begin
			st.hold_count = st.hold_count + 1'b1;
			if (st.hold_count > cfg.hold_limit) begin
				st.mode       = MODE_OFF;
				st.hold_count = '0;
			end
		end else begin
			st.hold_count = '0;
		end

		if (st.press_pending && !st.settling) begin
			st.settling      = 1'b1;
			st.settle_count  = '0;
			st.press_pending = 1'b0;
		end
		if (st.settling) begin
			st.settle_count = st.settle_count + 1'b1;
			if (st.settle_count >= cfg.debounce_limit) begin
				st.settling     = 1'b0;
				st.settle_count = '0;
				if (b) begin
					next_mode = st.mode + 2'd1;
					st.mode   = mode_t'(next_mode);
				end
			end
		end

		case (st.mode)
			MODE_OFF:  st.led = 1'b0;
			MODE_ON:   st.led = 1'b1;
			MODE_SLOW: st.led = blink_step(cfg.slow_period);
			default:   st.led = blink_step(cfg.fast_period);
		endcase

		r.led  = st.led;
		r.mode = st.mode;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lamp_t want;
		if (!arst_n) begin
			cfg      = '{DEBOUNCE_RST, HOLD_RST, SLOW_RST, FAST_RST};
			st       = STATE_RST;
			lamp_q.delete();
			errors   = 0;
			compared = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (lamp_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got led=%0b mode=%0d",
						$time, led, mode);
				end else begin
					want = lamp_q.pop_front();
					compared++;
					if (led !== want.led) begin
						errors++;
						$display("%0t: led mismatch, expected %0b, got %0b",
							$time, want.led, led);
					end
					if (mode !== want.mode) begin
						errors++;
						$display("%0t: mode mismatch, expected %0d, got %0d",
							$time, want.mode, mode);
					end
				end
			end
			if (req_valid && !req_stall)
				lamp_q.push_back(advance_tick(button));
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE: cfg.debounce_limit = cfg_data;
					REG_HOLD:     cfg.hold_limit     = cfg_data;
					REG_SLOW:     cfg.slow_period    = cfg_data;
					REG_FAST:     cfg.fast_period    = cfg_data;
					default:      ;
				endcase
			end
		end
		outstanding = lamp_q.size();
	end

endmodule

// ----- tb/button_mode_led_blinker_tb.sv -----
module button_mode_led_blinker_tb;
	import bmlb_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             button    = 1'b0;
	logic             rsp_stall = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             req_stall;
	logic             rsp_valid;
	logic             led;
	logic [1:0]       mode;

	int errors;
	int outstanding;
	int compared;
	int sent        = 0;
	int settings    = 0;
	int quiet_run   = 0;
	int idle_cycles = 0;
	bit calm        = 1'b0;

	button_mode_led_blinker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.button    (button),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.led       (led),
		.mode      (mode),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	blinker_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.button      (button),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.led         (led),
		.mode        (mode),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding),
		.compared    (compared)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always begin
		@(negedge clk);
		if (!calm && $urandom_range(0, 1)) begin
			rsp_stall = 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			rsp_stall = 1'b0;
		end
		repeat ($urandom_range(0, 30)) @(negedge clk);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 2000) begin
			$display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_tick(input logic b);
		if (!calm && quiet_run == 0) begin
			if ($urandom_range(0, 1)) begin
				req_valid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			quiet_run = $urandom_range(0, 30);
		end else if (quiet_run > 0) begin
			quiet_run--;
		end
		req_valid = 1'b1;
		button    = b;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic play(input string levels);
		for (int i = 0; i < levels.len(); i++)
			send_tick(levels[i] == "1");
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_config(input logic [CFG_W-1:0] debounce, hold, slow, fast);
		cfg_we    = 1'b1;
		cfg_index = REG_DEBOUNCE;
		cfg_data  = debounce;
		@(negedge clk);
		cfg_index = REG_HOLD;
		cfg_data  = hold;
		@(negedge clk);
		cfg_index = REG_SLOW;
		cfg_data  = slow;
		@(negedge clk);
		cfg_index = REG_FAST;
		cfg_data  = fast;
		@(negedge clk);
		cfg_we = 1'b0;
		settings++;
	endtask

	function automatic logic [CFG_W-1:0] pick_value(input logic [CFG_W-1:0] lo, hi, odd,
			input int small_hi);
		case ($urandom_range(0, 9))
			0:       return lo;
			1:       return hi;
			2:       return odd;
			default: return CFG_W'($urandom_range(lo, small_hi));
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0] d;
		logic [CFG_W-1:0] h;
		int budget;
		int base;
		int press;
		int r;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		play("0110");
		drain();
		load_config(16'd1, 16'd4, 16'd3, 16'd2);
		play("10100010011111");
		drain();
		load_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		play("10");
		drain();
		// zero debounce, hold that never trips, blink periods of 0 and 1
		load_config(16'd0, 16'hFFFF, 16'd0, 16'd1);
		play("101010");

		for (int ph = 0; ph < 13; ph++) begin
			drain();
			calm = (ph == 12);
			d = pick_value(16'd1, 16'hFFFF, 16'd0, 6);
			h = pick_value(16'd0, 16'hFFFE, 16'hFFFF, 30);
			load_config(d, h,
				pick_value(16'd2, 16'hFFFF, CFG_W'($urandom_range(0, 1)), 12),
				pick_value(16'd2, 16'hFFFF, CFG_W'($urandom_range(0, 1)), 12));
			budget = 0;
			while (budget < 100) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					press = $urandom_range(1, 6);
					repeat (press) send_tick(1'($urandom_range(0, 1)));
					budget += press;
				end else begin
					base = (d > 40) ? $urandom_range(1, 40) : ((d == 0) ? 1 : d);
					if (r >= 8)
						press = (base > 1) ? $urandom_range(1, base - 1) : 1;
					else if (r >= 6 && h < 60)
						press = h + 2;
					else
						press = base + $urandom_range(0, 3);
					repeat (press) send_tick(1'b1);
					r = $urandom_range(1, 6);
					repeat (r) send_tick(1'b0);
					budget += press + r;
				end
			end
		end
		drain();
		repeat (8) @(negedge clk);

		$display("%0d button ticks sent under %0d register settings, %0d results compared",
			sent, settings, compared);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
